/* src/cbz_pkg.sv */
package cbz_pkg;

	localparam int SAMPLE_STEPS   = 50;
	localparam int CONTROL_POINTS = 4;
	localparam int COORD_BITS     = 16;

	// sample number width, holds up to the largest step count
	localparam int IDX_W  = 6;
	// t is unsigned Q1.16
	localparam int T_FRAC = 16;
	localparam int T_W    = T_FRAC + 1;

	typedef struct packed {
		logic store_we;  // store the incoming point
		logic start;     // load working set for the first sample
		logic step;      // one de casteljau level
		logic hand;      // move finished sample to output, load next one
	} cbz_cmd_t;

	typedef struct packed {
		logic full;      // next point completes the curve
		logic last;      // current sample is the final one
	} cbz_sts_t;

endpackage

/* src/cbz_lerp.sv */
module cbz_lerp #(
	parameter int COORD_BITS = cbz_pkg::COORD_BITS
) (
	input  logic signed [COORD_BITS-1:0]    a,
	input  logic signed [COORD_BITS-1:0]    b,
	input  logic        [cbz_pkg::T_W-1:0]  t,
	output logic signed [COORD_BITS-1:0]    y
);

	localparam int PW = COORD_BITS + 1 + cbz_pkg::T_W + 1;

	logic signed [COORD_BITS:0]       diff;
	logic signed [cbz_pkg::T_W:0]     ts;
	logic signed [PW-1:0]             prod;
	logic signed [PW-1:0]             rnd;
	logic signed [PW-1:0]             sh;

	always_comb begin
		diff = (COORD_BITS+1)'(b) - (COORD_BITS+1)'(a);
		ts   = {1'b0, t};
		prod = PW'(diff) * PW'(ts);
		// round half toward +inf, then floor via arithmetic shift
		rnd  = prod + (PW'(1) <<< (cbz_pkg::T_FRAC - 1));
		sh   = rnd >>> cbz_pkg::T_FRAC;
		y    = a + sh[COORD_BITS-1:0];
	end

endmodule

/* src/cbz_datapath.sv */
module cbz_datapath #(
	parameter int SAMPLE_STEPS   = cbz_pkg::SAMPLE_STEPS,
	parameter int CONTROL_POINTS = cbz_pkg::CONTROL_POINTS,
	parameter int COORD_BITS     = cbz_pkg::COORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cbz_pkg::cbz_cmd_t               cmd,
	output cbz_pkg::cbz_sts_t               sts,
	input  logic signed [COORD_BITS-1:0]    point_x,
	input  logic signed [COORD_BITS-1:0]    point_y,
	output logic signed [COORD_BITS-1:0]    curve_x,
	output logic signed [COORD_BITS-1:0]    curve_y,
	output logic [cbz_pkg::IDX_W-1:0]       sample_index,
	output logic                            last_sample
);

	localparam int AW   = $clog2(CONTROL_POINTS);
	localparam int TW   = cbz_pkg::T_W;
	localparam int ONE  = 1 << cbz_pkg::T_FRAC;
	localparam int TINC = ONE / SAMPLE_STEPS;
	localparam int RINC = ONE % SAMPLE_STEPS;
	localparam int HALF = SAMPLE_STEPS / 2;
	localparam int RW   = $clog2(2 * SAMPLE_STEPS) + 1;

	logic signed [COORD_BITS-1:0] sx_q [CONTROL_POINTS];
	logic signed [COORD_BITS-1:0] sy_q [CONTROL_POINTS];
	logic signed [COORD_BITS-1:0] wx_q [CONTROL_POINTS];
	logic signed [COORD_BITS-1:0] wy_q [CONTROL_POINTS];
	logic signed [COORD_BITS-1:0] nx   [CONTROL_POINTS-1];
	logic signed [COORD_BITS-1:0] ny   [CONTROL_POINTS-1];

	logic [AW-1:0]             cnt_q;
	logic [cbz_pkg::IDX_W-1:0] k_q;
	logic [TW-1:0]             t_q;
	logic [RW-1:0]             r_q;
	logic [RW-1:0]             r_sum;
	logic                      reload;

	assign sts.full = cnt_q == AW'(CONTROL_POINTS - 1);
	assign sts.last = k_q == cbz_pkg::IDX_W'(SAMPLE_STEPS);
	assign reload   = cmd.start || (cmd.hand && !sts.last);
	assign r_sum    = r_q + RW'(RINC);

	for (genvar i = 0; i < CONTROL_POINTS - 1; i++) begin : g_lane
		cbz_lerp #(.COORD_BITS(COORD_BITS)) u_lx (
			.a(wx_q[i]), .b(wx_q[i+1]), .t(t_q), .y(nx[i])
		);
		cbz_lerp #(.COORD_BITS(COORD_BITS)) u_ly (
			.a(wy_q[i]), .b(wy_q[i+1]), .t(t_q), .y(ny[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			k_q   <= '0;
			t_q   <= '0;
			r_q   <= '0;
		end else begin
			if (cmd.store_we) begin
				cnt_q <= sts.full ? '0 : cnt_q + AW'(1);
			end
			if (cmd.start) begin
				k_q <= '0;
				t_q <= '0;
				r_q <= RW'(HALF);
			end else if (cmd.hand && !sts.last) begin
				// t = round(k * ONE / steps) tracked by quotient and remainder
				k_q <= k_q + cbz_pkg::IDX_W'(1);
				if (r_sum >= RW'(SAMPLE_STEPS)) begin
					r_q <= r_sum - RW'(SAMPLE_STEPS);
					t_q <= t_q + TW'(TINC) + TW'(1);
				end else begin
					r_q <= r_sum;
					t_q <= t_q + TW'(TINC);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			sx_q[cnt_q] <= point_x;
			sy_q[cnt_q] <= point_y;
		end
		if (reload) begin
			for (int i = 0; i < CONTROL_POINTS; i++) begin
				wx_q[i] <= sx_q[i];
				wy_q[i] <= sy_q[i];
			end
		end else if (cmd.step) begin
			for (int i = 0; i < CONTROL_POINTS - 1; i++) begin
				wx_q[i] <= nx[i];
				wy_q[i] <= ny[i];
			end
		end
		if (cmd.hand) begin
			curve_x      <= wx_q[0];
			curve_y      <= wy_q[0];
			sample_index <= k_q;
			last_sample  <= sts.last;
		end
	end

endmodule

/* src/cbz_ctrl.sv */
module cbz_ctrl #(
	parameter int CONTROL_POINTS = cbz_pkg::CONTROL_POINTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  cbz_pkg::cbz_sts_t   sts,
	output cbz_pkg::cbz_cmd_t   cmd
);

	localparam int LW = $clog2(CONTROL_POINTS);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_CALC  = 4'b0100,
		ST_HAND  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [LW-1:0] lvl_q;
	logic          out_valid_q;
	logic          accept;
	logic          out_free;

	assign in_stall  = state_q != ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.store_we = accept;
		cmd.start    = state_q == ST_START;
		cmd.step     = state_q == ST_CALC;
		cmd.hand     = (state_q == ST_HAND) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.hand) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && sts.full) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					lvl_q   <= '0;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (lvl_q == LW'(CONTROL_POINTS - 2)) begin
						state_q <= ST_HAND;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				ST_HAND: begin
					// wait until the output register can take the sample
					if (out_free) begin
						lvl_q   <= '0;
						state_q <= sts.last ? ST_IDLE : ST_CALC;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/cubic_bezier_sampler.sv */
// after the last control point is taken the controller passes the start state, then
// stays in the calc state while the lerp lanes compute one de casteljau level per cycle,
// then the hand state, which registers the point and waits while the output stalls.
// control points transfer one per cycle; input stalls while a curve is sampled.
// reset clears the point count, the controller and output valid; the point store
// and working registers are not reset.
module cubic_bezier_sampler #(
	parameter int SAMPLE_STEPS   = cbz_pkg::SAMPLE_STEPS,
	parameter int CONTROL_POINTS = cbz_pkg::CONTROL_POINTS,
	parameter int COORD_BITS     = cbz_pkg::COORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [COORD_BITS-1:0]    point_x,
	input  logic signed [COORD_BITS-1:0]    point_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [COORD_BITS-1:0]    curve_x,
	output logic signed [COORD_BITS-1:0]    curve_y,
	output logic [cbz_pkg::IDX_W-1:0]       sample_index,
	output logic                            last_sample
);

	cbz_pkg::cbz_cmd_t cmd;
	cbz_pkg::cbz_sts_t sts;

	cbz_ctrl #(
		.CONTROL_POINTS(CONTROL_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbz_datapath #(
		.SAMPLE_STEPS   (SAMPLE_STEPS),
		.CONTROL_POINTS (CONTROL_POINTS),
		.COORD_BITS     (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.point_x      (point_x),
		.point_y      (point_y),
		.curve_x      (curve_x),
		.curve_y      (curve_y),
		.sample_index (sample_index),
		.last_sample  (last_sample)
	);

endmodule
